>>> rtl/ktcq_pkg.sv
// ----------------------------------------------------------------------------
// ktcq_pkg
// shared types and constants for the key and ttl command qualifier
// ----------------------------------------------------------------------------
package ktcq_pkg;

  localparam int PERIOD_W = 16;
  localparam int HOLD_W   = 8;

  localparam logic [PERIOD_W-1:0] POLL_PERIOD_RESET    = 16'd100;
  localparam logic [HOLD_W-1:0]   HOLD_THRESHOLD_RESET = 8'd100;

  localparam logic [1:0] KEY_NONE       = 2'd0;
  localparam logic [1:0] KEY_CALIBRATE  = 2'd1;
  localparam logic [1:0] KEY_FULL_OPEN  = 2'd2;
  localparam logic [1:0] KEY_FULL_CLOSE = 2'd3;

  localparam logic [1:0] TTL_NONE   = 2'd0;
  localparam logic [1:0] TTL_LOCK   = 2'd1;
  localparam logic [1:0] TTL_UNLOCK = 2'd2;

  localparam logic CFG_POLL_PERIOD    = 1'b0;
  localparam logic CFG_HOLD_THRESHOLD = 1'b1;

  typedef struct packed {
    logic open_key_level;
    logic close_key_level;
    logic close_ttl_level;
  } in_word_t;

  typedef struct packed {
    logic [1:0] key_command;
    logic [1:0] ttl_command;
  } out_word_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] poll_period_ticks;
    logic [HOLD_W-1:0]   hold_threshold;
  } cfg_t;

endpackage

>>> rtl/key_ttl_command_qualifier_core.sv
// ----------------------------------------------------------------------------
// key_ttl_command_qualifier_core
// qualifies two active-low keys and the close ttl line into valve commands
//
//   port group   dir  handshake            word
//   in_*         in   in_valid / in_stall   ktcq_pkg::in_word_t, one tick
//   out_*        out  out_valid / out_stall ktcq_pkg::out_word_t, one command
//   cfg_*        in   cfg_write             index 0 poll period, 1 hold threshold
//
// one tick per cycle while in_stall is low; a word waits in the input register and
// its command, if any, moves on into the output register once that register is free
// the input register advances whenever the output register is empty or taken,
// so out_stall reaches in_stall only through a full output register
// reset clears the counters, the key history and both valid bits, and loads
// the register defaults of 100
// ----------------------------------------------------------------------------
module key_ttl_command_qualifier_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ktcq_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ktcq_pkg::out_word_t  out_word,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data
);
  import ktcq_pkg::*;

  cfg_t      cfg;
  logic      stage_valid;
  in_word_t  stage_word;
  logic      out_free;
  logic      advance;
  logic      res_valid;
  out_word_t res;

  assign out_free = !out_valid || !out_stall;
  assign advance  = stage_valid && out_free;
  assign in_stall = stage_valid && !out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_period_ticks <= POLL_PERIOD_RESET;
      cfg.hold_threshold    <= HOLD_THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_POLL_PERIOD:    cfg.poll_period_ticks <= cfg_data[PERIOD_W-1:0];
        CFG_HOLD_THRESHOLD: cfg.hold_threshold    <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stage_word <= in_word;
    end
  end

  ktcq_qualifier u_qualifier (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .word      (stage_word),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && res_valid) begin
      out_word <= res;
    end
  end

endmodule

>>> rtl/ktcq_qualifier.sv
// ----------------------------------------------------------------------------
// ktcq_qualifier
// tick counter, key and ttl qualification state, and command decode
// ----------------------------------------------------------------------------
module ktcq_qualifier (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  ktcq_pkg::in_word_t  word,
  input  ktcq_pkg::cfg_t      cfg,
  output logic              res_valid,
  output ktcq_pkg::out_word_t res
);
  import ktcq_pkg::*;

  logic [PERIOD_W-1:0] ticks;
  logic [PERIOD_W-1:0] ticks_next;
  logic [HOLD_W-1:0]   hold_count;
  logic [HOLD_W-1:0]   hold_count_next;
  logic                prev_open;
  logic                prev_open_next;
  logic                prev_close;
  logic                prev_close_next;
  logic                prev_ttl;
  logic                prev_ttl_next;

  logic [PERIOD_W:0]   tick_inc;
  logic                sample;
  logic [HOLD_W-1:0]   hold_inc;
  logic [1:0]          key_cmd;
  logic [1:0]          ttl_cmd;

  always_comb begin
    tick_inc        = {1'b0, ticks} + {{PERIOD_W{1'b0}}, 1'b1};
    sample          = tick_inc >= {1'b0, cfg.poll_period_ticks};
    hold_inc        = hold_count + {{(HOLD_W-1){1'b0}}, 1'b1};
    ticks_next      = ticks;
    hold_count_next = hold_count;
    prev_open_next  = prev_open;
    prev_close_next = prev_close;
    prev_ttl_next   = prev_ttl;
    key_cmd         = KEY_NONE;
    ttl_cmd         = TTL_NONE;
    if (!sample) begin
      ticks_next = tick_inc[PERIOD_W-1:0];
    end else begin
      ticks_next = '0;
      if (!word.open_key_level && !word.close_key_level) begin
        hold_count_next = hold_inc;
        if (hold_inc >= cfg.hold_threshold) begin
          key_cmd         = KEY_CALIBRATE;
          hold_count_next = '0;
        end
        prev_open_next  = 1'b0;
        prev_close_next = 1'b0;
      end else if (word.open_key_level != prev_open) begin
        if (!word.open_key_level) begin
          key_cmd = KEY_FULL_OPEN;
        end
        prev_open_next  = word.open_key_level;
        hold_count_next = '0;
      end else if (word.close_key_level != prev_close) begin
        if (!word.close_key_level) begin
          key_cmd = KEY_FULL_CLOSE;
        end
        prev_close_next = word.close_key_level;
        hold_count_next = '0;
      end else begin
        hold_count_next = '0;
      end
      if (word.close_ttl_level) begin
        ttl_cmd       = TTL_LOCK;
        prev_ttl_next = 1'b1;
      end else if (prev_ttl) begin
        ttl_cmd       = TTL_UNLOCK;
        prev_ttl_next = 1'b0;
      end
    end
    res_valid       = sample && (key_cmd != KEY_NONE || ttl_cmd != TTL_NONE);
    res.key_command = key_cmd;
    res.ttl_command = ttl_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks      <= '0;
      hold_count <= '0;
      prev_open  <= 1'b0;
      prev_close <= 1'b0;
      prev_ttl   <= 1'b1;
    end else if (fire) begin
      ticks      <= ticks_next;
      hold_count <= hold_count_next;
      prev_open  <= prev_open_next;
      prev_close <= prev_close_next;
      prev_ttl   <= prev_ttl_next;
    end
  end

endmodule
